@@ design/ibd_pkg.sv @@
// ibd_pkg: payload types, field table and helpers for the indoor bike data parser
package ibd_pkg;

  localparam int NUM_FIELDS = 10;

  typedef logic [3:0] fld_idx_t;
  typedef logic [2:0] fld_len_t;
  typedef logic [2:0] fld_slot_t;

  localparam fld_idx_t FLD_DONE = 4'd10;

  localparam fld_slot_t SLOT_SPEED      = 3'd0;
  localparam fld_slot_t SLOT_CADENCE    = 3'd1;
  localparam fld_slot_t SLOT_DISTANCE   = 3'd2;
  localparam fld_slot_t SLOT_RESISTANCE = 3'd3;
  localparam fld_slot_t SLOT_POWER      = 3'd4;
  localparam fld_slot_t SLOT_ENERGY     = 3'd5;
  localparam fld_slot_t SLOT_HEART      = 3'd6;
  localparam fld_slot_t SLOT_NONE       = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ibd_in_t;

  typedef struct packed {
    logic [15:0] speed_centi_kmh;
    logic [15:0] cadence_half_rpm;
    logic [23:0] distance_m;
    logic [15:0] resistance_level;
    logic [15:0] power_w;
    logic [15:0] energy_kcal;
    logic [7:0]  heart_bpm;
    logic [6:0]  present_mask;
    logic        short_packet;
  } ibd_out_t;

  typedef struct packed {
    logic packet_power_enable;
  } ibd_cfg_t;

  // bytes on the wire for each field
  function automatic fld_len_t fld_size(fld_idx_t idx);
    fld_len_t r;
    case (idx)
      4'd4:    r = 3'd3;
      4'd8:    r = 3'd5;
      4'd9:    r = 3'd1;
      default: r = 3'd2;
    endcase
    return r;
  endfunction

  // bytes that carry the stored value
  function automatic fld_len_t fld_vlen(fld_idx_t idx);
    fld_len_t r;
    case (idx)
      4'd4:    r = 3'd3;
      4'd9:    r = 3'd1;
      default: r = 3'd2;
    endcase
    return r;
  endfunction

  function automatic fld_slot_t fld_slot(fld_idx_t idx);
    fld_slot_t r;
    case (idx)
      4'd0:    r = SLOT_SPEED;
      4'd2:    r = SLOT_CADENCE;
      4'd4:    r = SLOT_DISTANCE;
      4'd5:    r = SLOT_RESISTANCE;
      4'd6:    r = SLOT_POWER;
      4'd8:    r = SLOT_ENERGY;
      4'd9:    r = SLOT_HEART;
      default: r = SLOT_NONE;
    endcase
    return r;
  endfunction

  // first present field at or after start, FLD_DONE when none
  function automatic fld_idx_t first_from(logic [NUM_FIELDS-1:0] pres, fld_idx_t start);
    fld_idx_t r;
    r = FLD_DONE;
    for (int i = NUM_FIELDS - 1; i >= 0; i--) begin
      if (pres[i] && (4'(i) >= start)) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ design/ibd_stream_if.sv @@
// ibd_stream_if: valid/ready channel carrying one payload beat
interface ibd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/indoor_bike_data_parser_unit.sv @@
// indoor_bike_data_parser_unit: byte-serial parser for indoor bike data notifications
//
// in_ch carries one notification byte per beat, last_byte marking the final one.
// The first two bytes form the flags word; later bytes are steered to the flagged
// fields by a field index and byte counter.
// On the last byte one result beat goes to out_ch in the next cycle, carrying the
// held values, the per-packet heart rate and update mask and the short-packet flag.
// Throughput is one input beat per cycle while out_ch does not stall.
// cfg_ch writes packet_power_enable (reset 1) and is always ready; write it only
// while the block is idle.
// out_ch has a single output register: a new beat is taken while the result is
// being taken in the same cycle; if out_ch stalls with a result pending, in_ch
// stops accepting until that result is taken.
// Reset (rst_n low, synchronous) clears held values, the packet state and the
// output valid; the first byte after reset starts a new packet.
module indoor_bike_data_parser_unit #(
  parameter int MAX_PACKET_BYTES = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  ibd_stream_if.sink   in_ch,
  ibd_stream_if.source out_ch,
  ibd_stream_if.sink   cfg_ch
);
  import ibd_pkg::*;

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [POS_W-1:0]      pos_r, pos_nxt, pos_upd;
  logic [7:0]            flag_lo_r, flag_lo_nxt;
  logic [NUM_FIELDS-1:0] pres_r, pres_nxt;
  fld_idx_t              idx_r, idx_nxt, idx_upd;
  fld_len_t              k_r, k_nxt;
  logic [23:0]           partial_r, partial_nxt;
  logic [15:0]           speed_r, speed_nxt;
  logic [15:0]           cadence_r, cadence_nxt;
  logic [23:0]           distance_r, distance_nxt;
  logic [15:0]           resist_r, resist_nxt;
  logic [15:0]           power_r, power_nxt;
  logic [15:0]           energy_r, energy_nxt;
  logic [7:0]            heart_r, heart_nxt, heart_upd;
  logic [6:0]            mask_r, mask_nxt, mask_upd;
  logic                  power_en_r;
  logic                  out_valid_r, out_valid_nxt;
  ibd_out_t              out_data_r, out_data_nxt;

  logic                  accept;
  logic                  last;
  logic [7:0]            b;
  logic [NUM_FIELDS-1:0] pres_new;

  assign in_ch.ready    = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_data_r;

  assign accept   = in_ch.valid && in_ch.ready;
  assign last     = in_ch.payload.last_byte;
  assign b        = in_ch.payload.data_byte;
  // speed is present when flag bit 0 is clear
  assign pres_new = {b[1:0], flag_lo_r} ^ NUM_FIELDS'(1);

  always_comb begin
    pos_upd      = pos_r;
    flag_lo_nxt  = flag_lo_r;
    pres_nxt     = pres_r;
    idx_upd      = idx_r;
    k_nxt        = k_r;
    partial_nxt  = partial_r;
    speed_nxt    = speed_r;
    cadence_nxt  = cadence_r;
    distance_nxt = distance_r;
    resist_nxt   = resist_r;
    power_nxt    = power_r;
    energy_nxt   = energy_r;
    heart_upd    = heart_r;
    mask_upd     = mask_r;
    if (accept && (pos_r < POS_W'(MAX_PACKET_BYTES))) begin
      pos_upd = pos_r + POS_W'(1);
      if (pos_r == '0) begin
        flag_lo_nxt = b;
      end else if (pos_r == POS_W'(1)) begin
        pres_nxt = pres_new;
        idx_upd  = first_from(pres_new, 4'd0);
        k_nxt    = '0;
      end else if (idx_r != FLD_DONE) begin
        if (k_r < fld_vlen(idx_r)) begin
          if (k_r == '0) begin
            partial_nxt = {16'b0, b};
          end else begin
            partial_nxt = partial_r | ({16'b0, b} << {k_r[1:0], 3'b000});
          end
          if (k_r == fld_vlen(idx_r) - 3'd1) begin
            case (fld_slot(idx_r))
              SLOT_SPEED: begin
                speed_nxt = partial_nxt[15:0];
                mask_upd[SLOT_SPEED] = 1'b1;
              end
              SLOT_CADENCE: begin
                cadence_nxt = partial_nxt[15:0];
                mask_upd[SLOT_CADENCE] = 1'b1;
              end
              SLOT_DISTANCE: begin
                distance_nxt = partial_nxt;
                mask_upd[SLOT_DISTANCE] = 1'b1;
              end
              SLOT_RESISTANCE: begin
                resist_nxt = partial_nxt[15:0];
                mask_upd[SLOT_RESISTANCE] = 1'b1;
              end
              SLOT_POWER: begin
                if (power_en_r) begin
                  power_nxt = partial_nxt[15:0];
                  mask_upd[SLOT_POWER] = 1'b1;
                end
              end
              SLOT_ENERGY: begin
                energy_nxt = partial_nxt[15:0];
                mask_upd[SLOT_ENERGY] = 1'b1;
              end
              SLOT_HEART: begin
                heart_upd = partial_nxt[7:0];
                mask_upd[SLOT_HEART] = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        if (k_r == fld_size(idx_r) - 3'd1) begin
          idx_upd = first_from(pres_r, idx_r + 4'd1);
          k_nxt   = '0;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_upd;
    idx_nxt   = idx_upd;
    heart_nxt = heart_upd;
    mask_nxt  = mask_upd;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (accept && last) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.speed_centi_kmh  = speed_nxt;
      out_data_nxt.cadence_half_rpm = cadence_nxt;
      out_data_nxt.distance_m       = distance_nxt;
      out_data_nxt.resistance_level = resist_nxt;
      out_data_nxt.power_w          = power_nxt;
      out_data_nxt.energy_kcal      = energy_nxt;
      out_data_nxt.heart_bpm        = heart_upd;
      out_data_nxt.present_mask     = mask_upd;
      out_data_nxt.short_packet     = (pos_upd < POS_W'(2)) || (idx_upd != FLD_DONE);
      pos_nxt   = '0;
      idx_nxt   = FLD_DONE;
      heart_nxt = '0;
      mask_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      idx_r       <= FLD_DONE;
      k_r         <= '0;
      speed_r     <= '0;
      cadence_r   <= '0;
      distance_r  <= '0;
      resist_r    <= '0;
      power_r     <= '0;
      energy_r    <= '0;
      heart_r     <= '0;
      mask_r      <= '0;
      power_en_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      speed_r     <= speed_nxt;
      cadence_r   <= cadence_nxt;
      distance_r  <= distance_nxt;
      resist_r    <= resist_nxt;
      power_r     <= power_nxt;
      energy_r    <= energy_nxt;
      heart_r     <= heart_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        power_en_r <= cfg_ch.payload.packet_power_enable;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    flag_lo_r  <= flag_lo_nxt;
    pres_r     <= pres_nxt;
    partial_r  <= partial_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ design/ibd_checker.sv @@
// ibd_checker: port-level assertions for the indoor bike data parser, with bind
module ibd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_heart,
  input logic [6:0] out_mask
);

  // result beat held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // last byte gives a result in the next cycle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no result after last byte");

  // a result only follows a last byte
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result without last byte");

  // heart rate reads zero when not updated in the packet
  a_heart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mask[6] |-> out_heart == 8'd0)
    else $error("heart rate set without mask bit");

endmodule

bind indoor_bike_data_parser_unit ibd_checker u_ibd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.payload.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_heart (out_ch.payload.heart_bpm),
  .out_mask  (out_ch.payload.present_mask)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking testbench for the indoor bike data parser, with its own byte-level parser model
module tb_top;
  import ibd_pkg::*;

  localparam int MAX_BYTES      = 31;
  localparam int LONGEST_PACKET = 40;
  localparam int GAP_MAX        = 18;
  localparam int SHOWN_MAX      = 10;
  localparam int FILL_RANDOM    = 256;
  localparam int N_FIELDS       = 10;

  localparam int FIELD_SIZE [N_FIELDS]  = '{2, 2, 2, 2, 3, 2, 2, 2, 5, 1};
  localparam int FIELD_VALUE [N_FIELDS] = '{2, 2, 2, 2, 3, 2, 2, 2, 2, 1};
  localparam fld_slot_t FIELD_TARGET [N_FIELDS] = '{
    SLOT_SPEED, SLOT_NONE, SLOT_CADENCE, SLOT_NONE, SLOT_DISTANCE,
    SLOT_RESISTANCE, SLOT_POWER, SLOT_NONE, SLOT_ENERGY, SLOT_HEART
  };

  logic clk = 1'b0;
  logic rst_n;

  always #4 clk = ~clk;

  ibd_stream_if #(.payload_t(ibd_in_t))  in_bus ();
  ibd_stream_if #(.payload_t(ibd_out_t)) out_bus ();
  ibd_stream_if #(.payload_t(ibd_cfg_t)) cfg_bus ();

  indoor_bike_data_parser_unit #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // parser model state
  logic        power_on;
  int          byte_pos;
  logic [15:0] flags_word;
  logic [23:0] field_acc;
  logic [15:0] speed_h;
  logic [15:0] cadence_h;
  logic [23:0] distance_h;
  logic [15:0] resistance_h;
  logic [15:0] power_h;
  logic [15:0] energy_h;
  logic [7:0]  heart_p;
  logic [6:0]  fresh_mask;

  ibd_out_t expected_reports[$];
  int       mismatches;
  int       bytes_sent;
  bit       tx_quiet;
  bit       rx_quiet;

  function automatic bit field_on(logic [15:0] fl, int i);
    return (i == 0) ? !fl[0] : fl[i];
  endfunction

  function automatic int packet_length(logic [15:0] fl);
    int len;
    len = 2;
    for (int i = 0; i < N_FIELDS; i++) begin
      if (field_on(fl, i)) begin
        len += FIELD_SIZE[i];
      end
    end
    return len;
  endfunction

  function automatic logic [7:0] random_content();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      return 8'h00;
    end
    if (pick == 1) begin
      return 8'hff;
    end
    return 8'($urandom);
  endfunction

  task automatic clear_model();
    power_on     = 1'b1;
    byte_pos     = 0;
    flags_word   = '0;
    field_acc    = '0;
    speed_h      = '0;
    cadence_h    = '0;
    distance_h   = '0;
    resistance_h = '0;
    power_h      = '0;
    energy_h     = '0;
    heart_p      = '0;
    fresh_mask   = '0;
  endtask

  task automatic store_field(fld_slot_t slot);
    bit keep;
    keep = 1'b1;
    case (slot)
      SLOT_SPEED: begin
        speed_h = field_acc[15:0];
      end
      SLOT_CADENCE: begin
        cadence_h = field_acc[15:0];
      end
      SLOT_DISTANCE: begin
        distance_h = field_acc;
      end
      SLOT_RESISTANCE: begin
        resistance_h = field_acc[15:0];
      end
      SLOT_POWER: begin
        if (power_on) begin
          power_h = field_acc[15:0];
        end else begin
          keep = 1'b0;
        end
      end
      SLOT_ENERGY: begin
        energy_h = field_acc[15:0];
      end
      SLOT_HEART: begin
        heart_p = field_acc[7:0];
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    if (keep) begin
      fresh_mask[slot] = 1'b1;
    end
  endtask

  task automatic load_byte(logic [7:0] b);
    int off;
    int k;
    off = 2;
    if (byte_pos == 0) begin
      flags_word = {8'h00, b};
    end else if (byte_pos == 1) begin
      flags_word[15:8] = b;
    end else begin
      for (int i = 0; i < N_FIELDS; i++) begin
        if (field_on(flags_word, i)) begin
          if (byte_pos < off + FIELD_SIZE[i]) begin
            k = byte_pos - off;
            if (k < FIELD_VALUE[i]) begin
              if (k == 0) begin
                field_acc = 24'(b);
              end else begin
                field_acc = field_acc | (24'(b) << (8 * k));
              end
              if (k == FIELD_VALUE[i] - 1) begin
                store_field(FIELD_TARGET[i]);
              end
            end
            break;
          end
          off += FIELD_SIZE[i];
        end
      end
    end
  endtask

  task automatic predict_beat(logic [7:0] b, logic l);
    ibd_out_t rep;
    if (byte_pos < MAX_BYTES) begin
      load_byte(b);
      byte_pos++;
    end
    if (l) begin
      rep.speed_centi_kmh  = speed_h;
      rep.cadence_half_rpm = cadence_h;
      rep.distance_m       = distance_h;
      rep.resistance_level = resistance_h;
      rep.power_w          = power_h;
      rep.energy_kcal      = energy_h;
      rep.heart_bpm        = heart_p;
      rep.present_mask     = fresh_mask;
      rep.short_packet     = (byte_pos < 2) || (byte_pos < packet_length(flags_word));
      expected_reports.push_back(rep);
      byte_pos   = 0;
      flags_word = '0;
      field_acc  = '0;
      heart_p    = '0;
      fresh_mask = '0;
    end
  endtask

  task automatic send_beat(logic [7:0] b, logic l);
    ibd_in_t beat;
    int gap;
    beat.data_byte = b;
    beat.last_byte = l;
    gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid   <= 1'b1;
    in_bus.payload <= beat;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_beat(b, l);
    bytes_sent++;
  endtask

  task automatic send_packet(logic [15:0] fl, int len, int fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        b = fl[7:0];
      end else if (i == 1) begin
        b = fl[15:8];
      end else if (fill == FILL_RANDOM) begin
        b = random_content();
      end else begin
        b = 8'(fill);
      end
      send_beat(b, i == len - 1);
    end
  endtask

  task automatic send_random_packet();
    logic [15:0] fl;
    int need;
    int len;
    int pick;
    fl   = 16'($urandom);
    need = packet_length(fl);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = need;
    end else if (pick < 85) begin
      len = $urandom_range(1, need - 1);
    end else begin
      len = $urandom_range(need + 1, LONGEST_PACKET);
    end
    send_packet(fl, len, FILL_RANDOM);
  endtask

  // hold off the sender until every report is back
  task automatic settle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_power_enable(logic v);
    ibd_cfg_t word;
    word.packet_power_enable = v;
    @(negedge clk);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.payload <= word;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    power_on = v;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic compare_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX) begin
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  task automatic test_packet_edges();
    // flags cut short after one byte
    send_packet(16'h00ff, 1, FILL_RANDOM);
    // no fields, reserved flag bits set, trailing bytes
    send_packet(16'hfc01, 6, FILL_RANDOM);
    // every field present, all ones
    send_packet(16'h03fe, packet_length(16'h03fe), 255);
    // speed only, zero value
    send_packet(16'h0000, 4, 0);
    // speed and energy present, energy cut short after its value bytes
    send_packet(16'h0100, 7, FILL_RANDOM);
  endtask

  task automatic test_power_gate();
    settle();
    set_power_enable(1'b0);
    send_packet(16'h0041, 4, FILL_RANDOM);
    settle();
    set_power_enable(1'b1);
    send_packet(16'h0041, 4, FILL_RANDOM);
  endtask

  task automatic test_random_traffic(int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      send_random_packet();
    end
  endtask

  task automatic test_random_power_off();
    settle();
    set_power_enable(1'b0);
    test_random_traffic(450);
    settle();
    set_power_enable(1'b1);
  endtask

  task automatic test_back_to_back();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    test_random_traffic(150);
    rx_quiet = 1'b0;
    test_random_traffic(150);
    tx_quiet = 1'b0;
    rx_quiet = 1'b1;
    test_random_traffic(150);
    rx_quiet = 1'b0;
  endtask

  initial begin : report_monitor
    ibd_out_t got;
    ibd_out_t want;
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
      repeat (gap) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got = out_bus.payload;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX) begin
          $display("report beat with nothing pending: mask %0h", got.present_mask);
        end
      end else begin
        want = expected_reports.pop_front();
        compare_field("speed_centi_kmh", 24'(want.speed_centi_kmh),
                      24'(got.speed_centi_kmh));
        compare_field("cadence_half_rpm", 24'(want.cadence_half_rpm),
                      24'(got.cadence_half_rpm));
        compare_field("distance_m", want.distance_m, got.distance_m);
        compare_field("resistance_level", 24'(want.resistance_level),
                      24'(got.resistance_level));
        compare_field("power_w", 24'(want.power_w), 24'(got.power_w));
        compare_field("energy_kcal", 24'(want.energy_kcal), 24'(got.energy_kcal));
        compare_field("heart_bpm", 24'(want.heart_bpm), 24'(got.heart_bpm));
        compare_field("present_mask", 24'(want.present_mask), 24'(got.present_mask));
        compare_field("short_packet", 24'(want.short_packet), 24'(got.short_packet));
      end
    end
  end

  initial begin : run_tests
    in_bus.valid    = 1'b0;
    in_bus.payload  = '0;
    out_bus.ready   = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.payload = '0;
    rst_n           = 1'b0;
    mismatches      = 0;
    bytes_sent      = 0;
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;
    clear_model();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    set_power_enable(1'b1);
    test_packet_edges();
    test_power_gate();
    test_random_traffic(450);
    test_random_power_off();
    test_back_to_back();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
